@@ design/sis_pkg.sv @@
// Shared types, constants and helpers of the sorted interval set unit.
package sis_pkg;

	localparam int CAPACITY    = 16;
	localparam int COORD_WIDTH = 32;
	localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int ADDR_W      = IDX_W + 1;
	localparam int RAM_DEPTH   = 2 ** ADDR_W;

	// operation codes
	localparam logic [2:0] F_ADD = 3'd0;
	localparam logic [2:0] F_SUB = 3'd1;
	localparam logic [2:0] F_REM = 3'd2;
	localparam logic [2:0] F_QRY = 3'd3;
	localparam logic [2:0] F_CLR = 3'd4;

	// status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct packed {
		logic [2:0]         func;
		logic signed [31:0] coord_low;
		logic signed [31:0] coord_high;
		logic [3:0]         entry_index;
	} in_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic       hit;
		logic [3:0] hit_index;
		logic [4:0] entry_count;
	} out_word_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	// reduce a 32-bit input coordinate to the internal width, sign kept
	function automatic coord_t to_coord(input logic signed [31:0] v);
		logic signed [63:0] w;
		w = 64'(v);
		return w[COORD_WIDTH-1:0];
	endfunction

endpackage

@@ design/sis_ram.sv @@
// Generic simple dual-port RAM with registered read.
module sis_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/sorted_interval_set_unit.sv @@
// Add into a full store, out-of-range remove, clear and unused codes are answered
// without a scan; other operations scan the store, reading one store entry per cycle,
// except where an entry splits or is placed before another and its second word goes out.
// Throughput: one word at a time; busy is high while a scan runs.
// Reset: count cleared, active bank 0; store contents are not cleared.
// Results come as a one-cycle done strobe and cannot be stalled.
module sorted_interval_set_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  sis_pkg::in_word_t  req,
	output logic               done,
	output sis_pkg::out_word_t rsp
);
	import sis_pkg::*;

	state_t             state_q;
	logic [2:0]         func_q;
	coord_t             olo_q, ohi_q, p_q, acc_lo_q, acc_hi_q, pend_lo_q, pend_hi_q;
	logic [3:0]         ridx_q;
	logic [CNT_W-1:0]   cnt_q, rd_ptr_q, wr_ptr_q;
	logic               bank_q, v_s1, pend_q, placed_q, rej_q, hit_q, done_q;
	logic [IDX_W-1:0]   idx_s1, hidx_q;
	out_word_t          rsp_q;

	logic [COORD_WIDTH-1:0] lo_rd, hi_rd;
	coord_t             a, b, lo_in, hi_in, olo_in, ohi_in;
	coord_t             e1_lo, e1_hi, e2_lo, e2_hi, w_lo, w_hi;
	logic               e1, e2, merge, split, qhit, dbl, we, fin_wr, accept, imm;
	logic [1:0]         imm_stat;
	logic [ADDR_W-1:0]  waddr, raddr;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign rsp    = rsp_q;

	// input ends, ordered
	assign lo_in  = to_coord(req.coord_low);
	assign hi_in  = to_coord(req.coord_high);
	assign olo_in = (hi_in < lo_in) ? hi_in : lo_in;
	assign ohi_in = (hi_in < lo_in) ? lo_in : hi_in;

	// words answered at once, without a scan
	always_comb begin
		imm      = 1'b0;
		imm_stat = STAT_OK;
		case (req.func) inside
			F_ADD: begin
				imm      = (cnt_q >= CNT_W'(CAPACITY));
				imm_stat = STAT_FULL;
			end
			F_REM: begin
				imm      = ({{CNT_W{1'b0}}, req.entry_index} >= {4'b0, cnt_q});
				imm_stat = STAT_RANGE;
			end
			F_SUB, F_QRY: imm = 1'b0;
			default: imm = 1'b1;
		endcase
	end

	// store banks: read the active one, rebuild into the other
	assign raddr = {bank_q, rd_ptr_q[IDX_W-1:0]};
	assign waddr = {~bank_q, wr_ptr_q[IDX_W-1:0]};

	sis_ram #(.WIDTH(COORD_WIDTH), .DEPTH(RAM_DEPTH)) u_ram_lo (
		.clk(clk), .we(we), .waddr(waddr), .wdata(w_lo), .raddr(raddr), .rdata(lo_rd)
	);
	sis_ram #(.WIDTH(COORD_WIDTH), .DEPTH(RAM_DEPTH)) u_ram_hi (
		.clk(clk), .we(we), .waddr(waddr), .wdata(w_hi), .raddr(raddr), .rdata(hi_rd)
	);

	assign a = $signed(lo_rd);
	assign b = $signed(hi_rd);

	// per-entry decision: up to two output entries
	always_comb begin
		e1 = 1'b0; e2 = 1'b0; merge = 1'b0; split = 1'b0; qhit = 1'b0;
		e1_lo = a; e1_hi = b; e2_lo = a; e2_hi = b;
		case (func_q)
			F_ADD: begin
				if (placed_q || b < olo_q) begin
					e1 = 1'b1;
				end else if (a > ohi_q) begin
					e1 = 1'b1; e1_lo = acc_lo_q; e1_hi = acc_hi_q; e2 = 1'b1;
				end else begin
					merge = 1'b1;
				end
			end
			F_SUB: begin
				if (b < olo_q || a > ohi_q) begin
					e1 = 1'b1;
				end else begin
					if (a < olo_q) begin
						e1 = 1'b1; e1_hi = olo_q;
					end
					if (ohi_q < b) begin
						e2 = 1'b1; e2_lo = ohi_q;
					end
					split = (a < olo_q) && (ohi_q < b);
				end
			end
			F_REM: e1 = ({4'b0, idx_s1} != {{IDX_W{1'b0}}, ridx_q});
			F_QRY: qhit = (a <= p_q) && (p_q <= b);
			default: ;
		endcase
	end

	assign dbl    = v_s1 && e1 && e2;
	assign fin_wr = (state_q == S_FIN) && (func_q == F_ADD) && !placed_q;
	assign we     = (state_q == S_SCAN) && (pend_q || (v_s1 && (e1 || e2))) || fin_wr;

	// write data select
	always_comb begin
		if (fin_wr) begin
			w_lo = acc_lo_q; w_hi = acc_hi_q;
		end else if (pend_q) begin
			w_lo = pend_lo_q; w_hi = pend_hi_q;
		end else if (e1) begin
			w_lo = e1_lo; w_hi = e1_hi;
		end else begin
			w_lo = e2_lo; w_hi = e2_hi;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= req.func;
			olo_q    <= olo_in;
			ohi_q    <= ohi_in;
			p_q      <= lo_in;
			ridx_q   <= req.entry_index;
			acc_lo_q <= olo_in;
			acc_hi_q <= ohi_in;
		end else if (state_q == S_SCAN && v_s1 && merge) begin
			acc_lo_q <= (a < acc_lo_q) ? a : acc_lo_q;
			acc_hi_q <= (b > acc_hi_q) ? b : acc_hi_q;
		end
		if (dbl) begin
			pend_lo_q <= e2_lo;
			pend_hi_q <= e2_hi;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			bank_q   <= 1'b0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			v_s1     <= 1'b0;
			idx_s1   <= '0;
			pend_q   <= 1'b0;
			placed_q <= 1'b0;
			rej_q    <= 1'b0;
			hit_q    <= 1'b0;
			hidx_q   <= '0;
			done_q   <= 1'b0;
			rsp_q    <= '0;
		end else begin
			done_q <= (accept && imm) || (state_q == S_FIN);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						rd_ptr_q <= '0;
						wr_ptr_q <= '0;
						v_s1     <= 1'b0;
						pend_q   <= 1'b0;
						placed_q <= 1'b0;
						rej_q    <= 1'b0;
						hit_q    <= 1'b0;
						hidx_q   <= '0;
						if (imm) begin
							rsp_q <= '{imm_stat, 1'b0, 4'd0,
								(req.func == F_CLR) ? 5'd0 : 5'(cnt_q)};
							if (req.func == F_CLR) cnt_q <= '0;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (v_s1 && func_q == F_ADD && e2) placed_q <= 1'b1;
					if (v_s1 && split && cnt_q >= CNT_W'(CAPACITY)) rej_q <= 1'b1;
					if (v_s1 && qhit && !hit_q) begin
						hit_q  <= 1'b1;
						hidx_q <= idx_s1;
					end
					pend_q   <= dbl;
					wr_ptr_q <= wr_ptr_q + CNT_W'(we);
					// issue next read unless a second word must go out first
					if (rd_ptr_q < cnt_q && !dbl) begin
						v_s1     <= 1'b1;
						idx_s1   <= rd_ptr_q[IDX_W-1:0];
						rd_ptr_q <= rd_ptr_q + 1'b1;
					end else begin
						v_s1 <= 1'b0;
					end
					if (rd_ptr_q == cnt_q && !v_s1 && !pend_q) state_q <= S_FIN;
				end
				S_FIN: begin
					state_q <= S_IDLE;
					case (func_q)
						F_ADD: begin
							cnt_q  <= wr_ptr_q + CNT_W'(!placed_q);
							rsp_q  <= '{STAT_OK, 1'b0, 4'd0,
								5'(wr_ptr_q + CNT_W'(!placed_q))};
							bank_q <= ~bank_q;
						end
						F_SUB: begin
							if (rej_q) begin
								rsp_q <= '{STAT_FULL, 1'b0, 4'd0, 5'(cnt_q)};
							end else begin
								cnt_q  <= wr_ptr_q;
								rsp_q  <= '{STAT_OK, 1'b0, 4'd0, 5'(wr_ptr_q)};
								bank_q <= ~bank_q;
							end
						end
						F_REM: begin
							cnt_q  <= wr_ptr_q;
							rsp_q  <= '{STAT_OK, 1'b0, 4'd0, 5'(wr_ptr_q)};
							bank_q <= ~bank_q;
						end
						F_QRY: rsp_q <= '{STAT_OK, hit_q, 4'(hidx_q), 5'(cnt_q)};
						default: rsp_q <= '{STAT_OK, 1'b0, 4'd0, 5'(cnt_q)};
					endcase
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ design/sis_checker.sv @@
// Port-level checks of the sorted interval set unit, bound to the top level.
module sis_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input sis_pkg::in_word_t  req,
	input logic               done,
	input sis_pkg::out_word_t rsp
);
	import sis_pkg::*;

	// a result word never shows while a scan is still running
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result word while busy");

	// a scan only begins from an accepted word
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy without start");

	// count never exceeds capacity
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.entry_count <= 5'(CAPACITY)))
		else $error("entry count beyond capacity");

	// a hit is a successful query naming a stored entry
	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.hit) |-> (rsp.status == STAT_OK && {1'b0, rsp.hit_index} < rsp.entry_count))
		else $error("hit index outside store");

endmodule

bind sorted_interval_set_unit sis_checker u_sis_checker (.*);

@@ verif/sorted_interval_set_unit_test.sv @@
// Testbench of the sorted interval set unit: random and directed words against a set model.
module sorted_interval_set_unit_test;
	import sis_pkg::*;

	localparam int WATCHDOG = 20000;

	// interval set model and store of expected answers
	class interval_scoreboard;
		coord_t    lo_q[$];
		coord_t    hi_q[$];
		out_word_t answers[$];
		int        errors;

		function void reset_set();
			lo_q.delete();
			hi_q.delete();
			answers.delete();
			errors = 0;
		endfunction

		// apply one accepted word to the model and queue its answer
		function void note_request(in_word_t w);
			coord_t    a, b, t, p;
			coord_t    nl[$];
			coord_t    nh[$];
			out_word_t r;
			int        first, last, k;
			a = to_coord(w.coord_low);
			b = to_coord(w.coord_high);
			p = a;
			if (b < a) begin
				t = a; a = b; b = t;
			end
			r = '0;
			r.status = STAT_OK;
			case (w.func)
				F_ADD: begin
					if (lo_q.size() >= CAPACITY) begin
						r.status = STAT_FULL;
					end else begin
						first = 0;
						while (first < lo_q.size() && hi_q[first] < a) first++;
						last = first;
						while (last < lo_q.size() && lo_q[last] <= b) last++;
						if (last == first) begin
							lo_q.insert(first, a);
							hi_q.insert(first, b);
						end else begin
							if (lo_q[first] < a) a = lo_q[first];
							if (hi_q[last-1] > b) b = hi_q[last-1];
							for (k = first; k < last; k++) begin
								lo_q.delete(first);
								hi_q.delete(first);
							end
							lo_q.insert(first, a);
							hi_q.insert(first, b);
						end
					end
				end
				F_SUB: begin
					for (k = 0; k < lo_q.size(); k++)
						if (lo_q[k] < a && b < hi_q[k] && lo_q.size() >= CAPACITY)
							r.status = STAT_FULL;
					if (r.status == STAT_OK) begin
						foreach (lo_q[i]) begin
							if (hi_q[i] < a || lo_q[i] > b) begin
								nl.push_back(lo_q[i]); nh.push_back(hi_q[i]);
							end else begin
								if (lo_q[i] < a) begin
									nl.push_back(lo_q[i]); nh.push_back(a);
								end
								if (b < hi_q[i]) begin
									nl.push_back(b); nh.push_back(hi_q[i]);
								end
							end
						end
						lo_q = nl;
						hi_q = nh;
					end
				end
				F_REM: begin
					if (w.entry_index >= lo_q.size()) begin
						r.status = STAT_RANGE;
					end else begin
						lo_q.delete(w.entry_index);
						hi_q.delete(w.entry_index);
					end
				end
				F_QRY: begin
					for (k = 0; k < lo_q.size() && !r.hit; k++)
						if (lo_q[k] <= p && p <= hi_q[k]) begin
							r.hit = 1'b1;
							r.hit_index = k[3:0];
						end
				end
				F_CLR: begin
					lo_q.delete();
					hi_q.delete();
				end
				default: ;
			endcase
			r.entry_count = 5'(lo_q.size());
			answers.push_back(r);
		endfunction

		function void report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch %s: got %0h expected %0h", what, got, want);
			errors++;
		endfunction

		// compare one answer with the oldest expectation
		function void check_answer(out_word_t got);
			out_word_t e;
			if (answers.size() == 0) begin
				report("unexpected word", 32'(got), 32'd0);
				return;
			end
			e = answers.pop_front();
			if (got.status != e.status)
				report("status", 32'(got.status), 32'(e.status));
			if (got.hit != e.hit) report("hit", 32'(got.hit), 32'(e.hit));
			if (got.hit_index != e.hit_index)
				report("hit_index", 32'(got.hit_index), 32'(e.hit_index));
			if (got.entry_count != e.entry_count)
				report("entry_count", 32'(got.entry_count), 32'(e.entry_count));
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_word_t  req;
	logic      done;
	out_word_t rsp;

	interval_scoreboard board;
	int idle_cycles = 0;
	int sent;

	sorted_interval_set_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) board.check_answer(rsp);
			if (done || (start && !busy)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles > WATCHDOG) begin
				$display("sorted_interval_set_unit_test: FAIL");
				$finish;
			end
		end
	end

	// random gap: mostly short, sometimes long, sometimes none
	task automatic pause();
		int n;
		n = $urandom_range(0, 9);
		if (n < 4) n = 0;
		else if (n < 9) n = $urandom_range(1, 3);
		else n = $urandom_range(10, 40);
		if (n > 0) start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// send one word and wait for it to be taken; start is dropped by the caller
	task automatic send(logic [2:0] f, logic [31:0] lo, logic [31:0] hi, logic [3:0] idx);
		in_word_t w;
		w.func = f;
		w.coord_low = lo;
		w.coord_high = hi;
		w.entry_index = idx;
		start <= 1'b1;
		req <= w;
		do @(posedge clk); while (busy);
		board.note_request(w);
		sent++;
	endtask

	// coordinate near a small grid so that entries meet, touch and nest
	function automatic logic [31:0] near_coord();
		int s;
		s = $urandom_range(0, 15);
		if (s == 0) return $urandom();
		if (s == 1) return {1'b1, 31'h0};
		if (s == 2) return 32'h7fffffff;
		return 32'(($signed($urandom_range(0, 40)) - 20) * 32'h1_0000);
	endfunction

	task automatic random_word(int mode);
		int f;
		logic [2:0] op;
		f = $urandom_range(0, 99);
		if (f < 45) op = F_ADD;
		else if (f < 70) op = F_SUB;
		else if (f < 82) op = F_REM;
		else if (f < 96) op = F_QRY;
		else if (f < 98 && mode > 0) op = F_CLR;
		else op = 3'($urandom_range(5, 7));
		send(op, (mode == 2) ? $urandom() : near_coord(),
			(mode == 2) ? $urandom() : near_coord(), 4'($urandom_range(0, 15)));
	endtask

	initial begin
		board = new();
		board.reset_set();
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty store, extremes, reversed ends, touching ends, splits
		send(F_QRY, 0, 0, 0);
		send(F_REM, 0, 0, 0);
		send(F_SUB, 0, 32'h10000, 0);
		send(F_ADD, 32'h7fffffff, {1'b1, 31'h0}, 0);
		send(F_QRY, {1'b1, 31'h0}, 0, 0);
		send(F_SUB, 32'h10000, 32'h20000, 0);
		send(F_SUB, 32'h20000, 32'h30000, 0);
		send(F_QRY, 32'h20000, 0, 0);
		send(F_CLR, 0, 0, 0);
		send(F_ADD, 32'h50000, 32'h40000, 0);
		send(F_ADD, 32'h50000, 32'h60000, 0);
		send(F_ADD, 32'h10000, 32'h20000, 0);
		send(F_ADD, 32'hffff0000, 32'hfffe0000, 0);
		send(3'd5, 32'hffffffff, 32'hffffffff, 4'hf);
		send(F_REM, 0, 0, 4'hf);
		send(F_REM, 0, 0, 4'd1);
		send(F_QRY, 32'h55555, 0, 0);
		send(F_CLR, 0, 0, 0);
		// fill the store, then try add and split while full
		for (int i = 0; i < CAPACITY; i++)
			send(F_ADD, i * 32'h40000, i * 32'h40000 + 32'h10000, 0);
		send(F_ADD, 32'h8000, 32'h8000, 0);
		send(F_SUB, 32'h4000, 32'h8000, 0);
		send(F_SUB, 32'h30000, 32'h40000, 0);
		send(F_QRY, 32'h3c0000, 0, 0);
		send(F_REM, 0, 0, 4'hf);
		send(3'd7, 0, 0, 0);

		// random part: mostly grid coordinates, some fully random
		for (int i = 0; i < 1300; i++) begin
			pause();
			random_word((i % 10 == 9) ? 2 : 1);
		end
		start <= 1'b0;

		while (board.answers.size() != 0) @(posedge clk);
		repeat (2 * CAPACITY + 10) @(posedge clk);
		if (board.errors == 0) $display("sorted_interval_set_unit_test: PASS");
		else $display("sorted_interval_set_unit_test: FAIL");
		$finish;
	end
endmodule

@@ sorted_interval_set_unit.f @@
design/sis_pkg.sv
design/sis_ram.sv
design/sorted_interval_set_unit.sv
design/sis_checker.sv
verif/sorted_interval_set_unit_test.sv
